>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle assertion failed");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle assertion failed");

`endif

>>> rtl/htd_pkg.sv
// ---------------------------------------------------------------------------
// Huffman tree decoder package
// Sizes, item types and node table types shared by the decoder modules.
// ---------------------------------------------------------------------------
package htd_pkg;

  localparam int NODE_COUNT   = 512;
  localparam int MAX_CODE_LEN = 16;

  localparam int IDX_W    = $clog2(NODE_COUNT);
  localparam int CNT_W    = $clog2(NODE_COUNT + 1);
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 16;
  localparam int LEN_W    = 5;
  localparam int POS_W    = $clog2(CODE_W);
  localparam int ENTRY_W  = 2 * IDX_W + SYM_W;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
    logic              bit_in;
  } in_item_t;

  typedef struct packed {
    logic             emitted;
    logic [SYM_W-1:0] symbol_out;
    logic             table_full;
    logic             bad_bit;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_entry_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic      idle;
    logic      done;
    out_item_t result;
  } htd_status_t;

endpackage

>>> rtl/huffman_tree_decoder.sv
// ---------------------------------------------------------------------------
// Huffman tree decoder
// Keeps a Huffman code tree in a node table RAM, builds it from load items
// and walks it one decode bit per item, returning one result item each.
//
//   Channel | Ports                          | Payload
//   input   | in_valid, in_ready, in_data    | in_item_t
//   output  | out_valid, out_ready, out_data | out_item_t
//
// A decode item reads the walk node, then the chosen child, both through the
// single read port of the node RAM. A decode bit with no matching child ends
// after the read of the walk node. A load item makes one RAM access per code
// level for min(code_len, MAX_CODE_LEN) levels, then writes the symbol, and
// ends early when the node table runs out. After reset a clearing pass
// writes all NODE_COUNT (512) node RAM entries while in_ready stays low.
// A result waits in an output register; a new item is taken once the walker
// is idle and that register is free or being emptied.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_tree_decoder import htd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               in_accept;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rdata;
  htd_status_t        status;

  assign in_ready  = status.idle && (!out_valid_r || out_ready);
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  htd_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_accept),
    .item    (in_data),
    .rdata   (rdata),
    .mem_req (mem_req),
    .status  (status)
  );

  htd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (status.done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = status.result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, !in_ready)
  `ASSERT_SAME(a_done_slot_free, clk, rst_n, status.done, !out_valid_r)
  `ASSERT_SAME(a_flags_exclusive, clk, rst_n, out_valid_r && out_data_r.emitted,
               !out_data_r.table_full && !out_data_r.bad_bit)

endmodule

>>> rtl/htd_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/htd_walker.sv
// ---------------------------------------------------------------------------
// Huffman tree walker
// Clears the node table, builds code paths for load items and follows
// one child per decode item, reading and writing the node table RAM.
// ---------------------------------------------------------------------------
module htd_walker import htd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  in_item_t           item,
  input  logic [ENTRY_W-1:0] rdata,
  output mem_req_t           mem_req,
  output htd_status_t        status
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_DEC1  = 3'd3;
  localparam logic [2:0] ST_DEC2  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [IDX_W-1:0]  walk_r, walk_nxt;
  logic [IDX_W-1:0]  node_r, node_nxt;
  logic              fresh_r, fresh_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CODE_W-1:0] bits_r, bits_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              bit_r, bit_nxt;

  node_entry_t       entry;
  node_entry_t       wentry;
  logic [LEN_W-1:0]  pos;
  logic              code_bit;
  logic [IDX_W-1:0]  link;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      used_r  <= CNT_W'(1);
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      walk_r  <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    fresh_r <= fresh_nxt;
    len_r   <= len_nxt;
    bits_r  <= bits_nxt;
    sym_r   <= sym_nxt;
    bit_r   <= bit_nxt;
  end

  assign entry    = fresh_r ? node_entry_t'('0) : node_entry_t'(rdata);
  assign pos      = len_r - LEN_W'(1);
  assign code_bit = (int'(pos) < CODE_W) ? bits_r[pos[POS_W-1:0]] : 1'b0;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    used_nxt  = used_r;
    walk_nxt  = walk_r;
    node_nxt  = node_r;
    fresh_nxt = fresh_r;
    len_nxt   = len_r;
    bits_nxt  = bits_r;
    sym_nxt   = sym_r;
    bit_nxt   = bit_r;
    wentry    = entry;
    link      = '0;
    mem_req   = '0;
    status    = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
        clr_nxt       = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        status.idle = 1'b1;
        if (start) begin
          sym_nxt   = item.symbol;
          bits_nxt  = item.code_bits;
          bit_nxt   = item.bit_in;
          fresh_nxt = 1'b0;
          mem_req.re = 1'b1;
          if (item.kind == KIND_LOAD) begin
            node_nxt      = '0;
            mem_req.raddr = '0;
            if (int'(item.code_len) > MAX_CODE_LEN) begin
              len_nxt = LEN_W'(MAX_CODE_LEN);
            end else begin
              len_nxt = item.code_len;
            end
            state_nxt = ST_LOAD;
          end else begin
            mem_req.raddr = walk_r;
            state_nxt     = ST_DEC1;
          end
        end
      end

      ST_LOAD: begin
        if (len_r == '0) begin
          wentry.sym    = sym_r;
          mem_req.we    = 1'b1;
          mem_req.waddr = node_r;
          mem_req.wdata = wentry;
          status.done   = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          link = code_bit ? entry.right : entry.left;
          if (link == '0) begin
            if (used_r >= CNT_W'(NODE_COUNT)) begin
              status.done              = 1'b1;
              status.result.table_full = 1'b1;
              state_nxt                = ST_IDLE;
            end else begin
              if (code_bit) begin
                wentry.right = used_r[IDX_W-1:0];
              end else begin
                wentry.left = used_r[IDX_W-1:0];
              end
              mem_req.we    = 1'b1;
              mem_req.waddr = node_r;
              mem_req.wdata = wentry;
              node_nxt      = used_r[IDX_W-1:0];
              used_nxt      = used_r + CNT_W'(1);
              fresh_nxt     = 1'b1;
              len_nxt       = len_r - LEN_W'(1);
            end
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = link;
            node_nxt      = link;
            fresh_nxt     = 1'b0;
            len_nxt       = len_r - LEN_W'(1);
          end
        end
      end

      ST_DEC1: begin
        link = bit_r ? entry.right : entry.left;
        if (link == '0) begin
          status.done           = 1'b1;
          status.result.bad_bit = 1'b1;
          state_nxt             = ST_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = link;
          node_nxt      = link;
          state_nxt     = ST_DEC2;
        end
      end

      ST_DEC2: begin
        status.done = 1'b1;
        if (entry.left == '0 && entry.right == '0) begin
          status.result.emitted    = 1'b1;
          status.result.symbol_out = entry.sym;
          walk_nxt                 = '0;
        end else begin
          walk_nxt = node_r;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> bench/tb_huffman_tree_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman tree decoder testbench
// Loads prefix codes into the node table and streams decode bits through the
// block with random sender gaps and receiver stalls. Every result item is
// checked field by field against a tree model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_huffman_tree_decoder;
  import htd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  huffman_tree_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Tree model: links, symbols, allocation count and walk position.
  int unsigned tree_left [NODE_COUNT];
  int unsigned tree_right [NODE_COUNT];
  logic [SYM_W-1:0] tree_sym [NODE_COUNT];
  int unsigned nodes_taken;
  int unsigned walk_node;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int unsigned code_set_bits [$];
  int unsigned code_set_len [$];

  int mismatches = 0;
  int cycle_count = 0;
  logic in_fire;
  int burst_left = 1;
  int idle_left = 0;
  logic [15:0] ready_mask = 16'hFFFF;
  logic [5:0] ready_step = '0;

  function automatic out_item_t tree_step(in_item_t it);
    out_item_t r;
    int unsigned node;
    int unsigned n;
    int unsigned nxt;
    bit b;
    bit full;
    r = '0;
    if (it.kind == KIND_LOAD) begin
      node = 0;
      full = 1'b0;
      n = 32'(it.code_len);
      if (n > MAX_CODE_LEN) n = MAX_CODE_LEN;
      while (n > 0 && !full) begin
        b = it.code_bits[n-1];
        nxt = b ? tree_right[node] : tree_left[node];
        if (nxt == 0) begin
          if (nodes_taken >= NODE_COUNT) begin
            full = 1'b1;
          end else begin
            nxt = nodes_taken;
            if (b) tree_right[node] = nxt;
            else tree_left[node] = nxt;
            nodes_taken++;
          end
        end
        if (!full) begin
          node = nxt;
          n--;
        end
      end
      if (!full) tree_sym[node] = it.symbol;
      r.table_full = full;
    end else begin
      nxt = it.bit_in ? tree_right[walk_node] : tree_left[walk_node];
      if (nxt == 0) begin
        r.bad_bit = 1'b1;
      end else if (tree_left[nxt] == 0 && tree_right[nxt] == 0) begin
        r.emitted = 1'b1;
        r.symbol_out = tree_sym[nxt];
        walk_node = 0;
      end else begin
        walk_node = nxt;
      end
    end
    return r;
  endfunction

  function automatic in_item_t make_load(logic [7:0] sym, logic [15:0] bits,
                                         logic [4:0] len);
    in_item_t it;
    it.kind = KIND_LOAD;
    it.symbol = sym;
    it.code_bits = bits;
    it.code_len = len;
    it.bit_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t make_decode(logic bit_val);
    in_item_t it;
    it.kind = KIND_DECODE;
    it.symbol = 8'($urandom_range(0, 255));
    it.code_bits = 16'($urandom_range(0, 65535));
    it.code_len = 5'($urandom_range(0, 31));
    it.bit_in = bit_val;
    return it;
  endfunction

  // Places random bits above the code so that only the low len bits matter.
  function automatic logic [15:0] pad_code(int unsigned bits, int unsigned len);
    logic [31:0] tmp;
    tmp = ($urandom() << len) | bits;
    return tmp[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Mostly decode bits; a few loads overwrite a known code or add a short one.
  task automatic push_decodes(int count);
    int i;
    int r;
    int k;
    int unsigned len;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4 && code_set_len.size() > 0) begin
        k = $urandom_range(0, code_set_len.size() - 1);
        len = code_set_len[k];
        pending_items.push_back(make_load(8'($urandom_range(0, 255)),
          pad_code(code_set_bits[k], len), 5'(len)));
      end else if (r < 6) begin
        len = $urandom_range(0, 8);
        pending_items.push_back(make_load(8'($urandom_range(0, 255)),
          16'($urandom_range(0, 65535)), 5'(len)));
      end else begin
        pending_items.push_back(make_decode(1'($urandom_range(0, 1))));
      end
    end
  endtask

  // Builds a complete prefix code by splitting leaves, loads it in random
  // order, then streams decode bits over it.
  task automatic push_code_phase(int splits, int max_len, int decodes);
    int unsigned leaf_bits [$];
    int unsigned leaf_len [$];
    int s;
    int k;
    int unsigned b;
    int unsigned l;
    int unsigned len_field;
    leaf_bits.push_back(0);
    leaf_len.push_back(0);
    for (s = 0; s < splits; s++) begin
      k = $urandom_range(0, leaf_len.size() - 1);
      if (leaf_len[k] < max_len) begin
        b = leaf_bits[k];
        l = leaf_len[k];
        leaf_bits.delete(k);
        leaf_len.delete(k);
        leaf_bits.push_back(b << 1);
        leaf_len.push_back(l + 1);
        leaf_bits.push_back((b << 1) | 1);
        leaf_len.push_back(l + 1);
      end
    end
    code_set_bits = leaf_bits;
    code_set_len = leaf_len;
    while (leaf_len.size() > 0) begin
      k = $urandom_range(0, leaf_len.size() - 1);
      l = leaf_len[k];
      len_field = l;
      if (l == MAX_CODE_LEN && $urandom_range(0, 1)) len_field = $urandom_range(17, 31);
      pending_items.push_back(make_load(8'($urandom_range(0, 255)),
        pad_code(leaf_bits[k], l), 5'(len_field)));
      leaf_bits.delete(k);
      leaf_len.delete(k);
    end
    push_decodes(decodes);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        expected_results.push_back(tree_step(in_data));
      end
      if (!in_valid || in_fire) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with nothing expected", 32'(out_data), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.emitted !== want.emitted)
          report_mismatch("emitted", 32'(out_data.emitted), 32'(want.emitted));
        if (out_data.symbol_out !== want.symbol_out)
          report_mismatch("symbol_out", 32'(out_data.symbol_out), 32'(want.symbol_out));
        if (out_data.table_full !== want.table_full)
          report_mismatch("table_full", 32'(out_data.table_full), 32'(want.table_full));
        if (out_data.bad_bit !== want.bad_bit)
          report_mismatch("bad_bit", 32'(out_data.bad_bit), 32'(want.bad_bit));
      end
    end
    if (ready_step == 6'd0) begin
      ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    end
    out_ready <= ready_mask[ready_step[3:0]];
    ready_step = ready_step + 6'd1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < NODE_COUNT; i++) begin
      tree_left[i] = 0;
      tree_right[i] = 0;
      tree_sym[i] = '0;
    end
    nodes_taken = 1;
    walk_node = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    pending_items.push_back(make_decode(1'b0));
    pending_items.push_back(make_decode(1'b1));
    pending_items.push_back(make_load(8'hA5, 16'h0000, 5'd0));
    pending_items.push_back(make_decode(1'b0));
    pending_items.push_back(make_load(8'h00, 16'h0000, 5'd1));
    pending_items.push_back(make_load(8'hFF, 16'hFFFF, 5'd1));
    pending_items.push_back(make_decode(1'b0));
    pending_items.push_back(make_decode(1'b1));
    pending_items.push_back(make_load(8'h12, 16'h0002, 5'd2));
    pending_items.push_back(make_decode(1'b1));
    pending_items.push_back(make_decode(1'b1));
    pending_items.push_back(make_decode(1'b0));
    pending_items.push_back(make_decode(1'b1));
    pending_items.push_back(make_load(8'h77, 16'h0000, 5'd1));
    pending_items.push_back(make_decode(1'b0));
    pending_items.push_back(make_decode(1'b0));
    pending_items.push_back(make_load(8'h3C, 16'hFFFF, 5'd31));
    pending_items.push_back(make_decode(1'b1));
    pending_items.push_back(make_decode(1'b1));
    pending_items.push_back(make_decode(1'b0));
    pending_items.push_back(make_load(8'h5A, 16'hAAAA, 5'd16));
    pending_items.push_back(make_load(8'h81, 16'h5555, 5'd16));
    pending_items.push_back(make_load(8'hC3, 16'h8000, 5'd17));
    wait_for_drain();

    push_code_phase(12, 6, 280);
    wait_for_drain();

    push_code_phase(40, MAX_CODE_LEN, 320);
    wait_for_drain();

    // Long random codes until the node table runs out.
    pending_items.push_back(make_load(8'h00, 16'($urandom_range(0, 65535)), 5'd16));
    pending_items.push_back(make_load(8'hFF, 16'($urandom_range(0, 65535)), 5'd16));
    for (i = 0; i < 68; i++) begin
      pending_items.push_back(make_load(8'($urandom_range(0, 255)),
        16'($urandom_range(0, 65535)), 5'd16));
    end
    push_decodes(200);
    wait_for_drain();

    for (i = 0; i < 200; i++) begin
      if ($urandom_range(0, 1))
        pending_items.push_back(make_decode(1'($urandom_range(0, 1))));
      else
        pending_items.push_back(make_load(8'($urandom_range(0, 255)),
          16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31))));
    end
    wait_for_drain();
    repeat (60) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
